@@ rtl/efg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efg_pkg
// shared types, constants and helper functions for the event flag group
// ----------------------------------------------------------------------------
package efg_pkg;

	localparam int NUM_SLOTS  = 64;
	localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int KIND_W     = 3;
	localparam int SLOT_W     = 6;
	localparam int STATUS_W   = 2;
	localparam int S_TDATA_W  = 8;
	localparam int M_TDATA_W  = 8;

	typedef enum logic [KIND_W-1:0] {
		KIND_ADD      = 3'd0,
		KIND_REMOVE   = 3'd1,
		KIND_SET      = 3'd2,
		KIND_CLEAR    = 3'd3,
		KIND_TEST_ONE = 3'd4,
		KIND_TEST_ANY = 3'd5,
		KIND_TEST_ALL = 3'd6
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_ALLOC = 2'd1,
		ST_NOT_SIG   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef logic [NUM_SLOTS-1:0] slot_vec_t;

	// index of the lowest set bit, zero when none is set
	function automatic logic [SLOT_IDX_W-1:0] lowest_index(input slot_vec_t v);
		logic [SLOT_IDX_W-1:0] idx;
		idx = '0;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_IDX_W'(i);
			end
		end
		return idx;
	endfunction

	// isolate the lowest set bit
	function automatic slot_vec_t lowest_onehot(input slot_vec_t v);
		return v & (~v + slot_vec_t'(1));
	endfunction

endpackage

@@ rtl/event_flag_group_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_flag_group_top
// bank of event flags with add, remove, set, clear and immediate tests
// ----------------------------------------------------------------------------
// usage:
//   operations arrive on the s_ stream: s_tuser carries the kind, s_tdata the
//   slot and the manual reset mode. every operation yields exactly one result
//   on the m_ stream: status and the claimed, found or echoed slot.
//   an operation is latched in an input register, resolved against the flag
//   bank by one pass of priority encoders and masked updates, and its result
//   is written to an output register in the same cycle the bank is updated.
//   path: an accepted transaction is held in the input register, and its result
//   moves to the output register, shown on m_tvalid, once that register is free.
//   throughput: one operation per cycle while the receiver does not stall,
//   set by the single bank update pass.
//   reset clears every allocated, signalled and manual mark and empties both
//   registers. when the receiver stalls, the result is held in the output
//   register, one more operation waits in the input register, and s_tready
//   drops only once both are occupied.
// ----------------------------------------------------------------------------
module event_flag_group_top import efg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // slot[5:0], manual_mode[6], zero[7]
	input  logic [KIND_W-1:0]    s_tuser,  // kind[2:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // status[1:0], found_slot[7:2]
);

	logic              valid_s1;
	kind_t             kind_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic              manual_s1;

	logic              out_valid_q;
	status_t           status_q;
	logic [SLOT_W-1:0] found_q;

	slot_vec_t sig_q, alloc_q, man_q;
	slot_vec_t sig_d, alloc_d, man_d;
	slot_vec_t sel, free_v, pick;
	status_t           status_d;
	logic [SLOT_W-1:0] found_d;
	logic              hit;
	logic              advance;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1   <= kind_t'(s_tuser);
			slot_s1   <= s_tdata[SLOT_W-1:0];
			manual_s1 <= s_tdata[SLOT_W];
		end
	end

	// slot decode and allocation check
	always_comb begin
		for (int i = 0; i < NUM_SLOTS; i++) begin
			sel[i] = (32'(slot_s1) == i);
		end
		hit    = |(sel & alloc_q);
		free_v = ~alloc_q;
	end

	always_comb begin
		sig_d    = sig_q;
		alloc_d  = alloc_q;
		man_d    = man_q;
		status_d = ST_OK;
		found_d  = slot_s1;
		pick     = '0;
		case (kind_s1)
			KIND_ADD: begin
				if (|free_v) begin
					pick    = lowest_onehot(free_v);
					alloc_d = alloc_q | pick;
					sig_d   = sig_q & ~pick;
					man_d   = manual_s1 ? (man_q | pick) : (man_q & ~pick);
					found_d = SLOT_W'(lowest_index(free_v));
				end else begin
					status_d = ST_FULL;
				end
			end
			KIND_REMOVE: begin
				if (!hit) begin
					status_d = ST_NOT_ALLOC;
				end else begin
					alloc_d = alloc_q & ~sel;
					sig_d   = sig_q & ~sel;
					man_d   = man_q & ~sel;
				end
			end
			KIND_SET: begin
				if (!hit) begin
					status_d = ST_NOT_ALLOC;
				end else begin
					sig_d = sig_q | sel;
				end
			end
			KIND_CLEAR: begin
				if (!hit) begin
					status_d = ST_NOT_ALLOC;
				end else begin
					sig_d = sig_q & ~sel;
				end
			end
			KIND_TEST_ONE: begin
				if (!hit) begin
					status_d = ST_NOT_ALLOC;
				end else if (!(|(sig_q & sel))) begin
					status_d = ST_NOT_SIG;
				end else begin
					sig_d = sig_q & (man_q | ~sel);
				end
			end
			KIND_TEST_ANY: begin
				if (|sig_q) begin
					pick    = lowest_onehot(sig_q);
					sig_d   = sig_q & (man_q | ~pick);
					found_d = SLOT_W'(lowest_index(sig_q));
				end else begin
					status_d = ST_NOT_SIG;
				end
			end
			KIND_TEST_ALL: begin
				if (sig_q != alloc_q) begin
					status_d = ST_NOT_SIG;
				end else begin
					sig_d = sig_q & man_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sig_q   <= '0;
			alloc_q <= '0;
			man_q   <= '0;
		end else if (advance) begin
			sig_q   <= sig_d;
			alloc_q <= alloc_d;
			man_q   <= man_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			found_q  <= found_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {found_q, status_q};

endmodule

@@ rtl/event_flag_group_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_flag_group_checker
// port level checks for the event flag group, bound to the top level
// ----------------------------------------------------------------------------
module event_flag_group_checker import efg_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic [KIND_W-1:0]    s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata
);

	// stalled result stays valid
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// stalled result keeps its data
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	// waiting input transaction stays put
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !s_tready |=> s_tvalid && $stable({s_tuser, s_tdata}))
		else $error("input transaction changed while waiting");

	// empty output means the input side can take a transaction
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// an accepted transaction reaches the output
	a_result_arrives: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> ##2 m_tvalid)
		else $error("result missing after accepted transaction");

endmodule

bind event_flag_group_top event_flag_group_checker u_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
